// ===== rtl/ihq_pkg.sv =====
// Package with the payload types, operation and status codes of the heap queue.
package ihq_pkg;

    // Input and result beats.
    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         item_id;
        logic signed [31:0] key;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         out_id;
        logic signed [31:0] out_key;
        logic [4:0]         count;
    } out_t;

    // Function codes on the input.
    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_INC    = 3'd1;
    localparam logic [2:0] FN_DEC    = 3'd2;
    localparam logic [2:0] FN_REMOVE = 3'd3;
    localparam logic [2:0] FN_QUERY  = 3'd4;

    // Internal operation codes after classification.
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_INC    = 3'd2;
    localparam logic [2:0] OP_DEC    = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_ABSENT  = 3'd4;
    localparam logic [2:0] ST_NOMOVE  = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;

    // Classified command passed from the front end to the execution unit.
    typedef struct packed {
        logic [2:0]         op;
        logic               in_range;
        logic [3:0]         id;
        logic signed [31:0] key;
    } cmd_t;

endpackage

// ===== rtl/indexed_max_heap_queue.sv =====
// Top level of the indexed max-heap priority queue.
//
// Input channel in_valid/in_ready carries one operation beat: insert, raise
// key, lower key, remove max, or query, naming an id and a key. Output
// channel out_valid/out_ready carries one result beat for every input beat,
// in order: status, id, key and element count after the operation.
// A front end decodes each beat and range-checks its id; a two-entry queue
// holds commands for the execution unit, so input beats are taken while the
// unit works or while a result waits.
// An error, query or no-op passes from the command queue through the state
// and result registers into the output register. Insert and raise key walk
// up, lower key and remove max walk down, one heap level per cycle, before
// the result is registered. The sift walk of the single execution unit
// sets the throughput.
// Reset empties the queue: count zero, no id present, no result pending.
// When the receiver stalls, the result is held in the output register and
// the unit waits; the command queue fills and then in_ready falls.
module indexed_max_heap_queue
    import ihq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    cmd_t cmd_in;
    cmd_t cmd_out;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign in_ready = !q_full;

    ihq_front #(.CAPACITY(CAPACITY)) u_front (
        .item (in_data),
        .cmd  (cmd_in)
    );

    ihq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_data (cmd_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (cmd_out)
    );

    ihq_back #(.CAPACITY(CAPACITY)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (cmd_out),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );

endmodule

// ===== rtl/ihq_front.sv =====
// Front end: decodes the function code and range-checks the id of each input beat.
module ihq_front
    import ihq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  in_t  item,
    output cmd_t cmd
);

    // Decode the function and check the id against the capacity.
    always_comb
    begin
        cmd.id       = item.item_id;
        cmd.key      = item.key;
        cmd.in_range = (32'(item.item_id) < 32'(CAPACITY));
        case (item.func)
            FN_INSERT: cmd.op = OP_INSERT;
            FN_INC:    cmd.op = OP_INC;
            FN_DEC:    cmd.op = OP_DEC;
            FN_REMOVE: cmd.op = OP_REMOVE;
            FN_QUERY:  cmd.op = OP_QUERY;
            default:   cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/ihq_fifo.sv =====
// Two-entry command queue between the front end and the execution unit.
module ihq_fifo
    import ihq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    cmd_t       data_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = data_reg[rd_ptr_reg];

    // Pointer and fill updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/ihq_back.sv =====
// Execution unit: heap storage, status checks, sift sequencer and output register.
module ihq_back
    import ihq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    localparam int NID = (CAPACITY < 16) ? CAPACITY : 16;
    localparam int PW  = $clog2(NID);
    localparam int CW  = $clog2(NID + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UP   = 2'd1;
    localparam logic [1:0] S_DOWN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // Heap slots hold id and key; a position table maps id to slot.
    logic [PW-1:0]      heap_id_reg  [NID];
    logic signed [31:0] heap_key_reg [NID];
    logic [PW-1:0]      pos_reg      [NID];
    logic [NID-1:0]     present_reg, present_next;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]      hole_reg, hole_next;
    logic [PW-1:0]      cur_id_reg, cur_id_next;
    logic signed [31:0] cur_key_reg, cur_key_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic [3:0]         res_id_reg, res_id_next;
    logic signed [31:0] res_key_reg, res_key_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    // Write ports of the stores.
    logic               heap_we;
    logic [PW-1:0]      heap_wslot;
    logic [PW-1:0]      heap_wid;
    logic signed [31:0] heap_wkey;
    logic               pos_we;
    logic [PW-1:0]      pos_wid;
    logic [PW-1:0]      pos_wval;

    // Lookups for the command at the head of the queue.
    logic [PW-1:0]      cid;
    logic [PW-1:0]      cpos;
    logic signed [31:0] ckey;
    logic [PW-1:0]      last_slot;

    // Neighbors of the hole.
    logic [PW-1:0]      parent;
    logic [PW+1:0]      left_w;
    logic [PW+1:0]      right_w;
    logic [PW-1:0]      left_i;
    logic [PW-1:0]      right_i;
    logic [PW-1:0]      best_i;

    assign cid       = cmd.id[PW-1:0];
    assign cpos      = pos_reg[cid];
    assign ckey      = heap_key_reg[cpos];
    assign last_slot = PW'(cnt_reg - CW'(1));
    assign parent    = PW'((hole_reg - PW'(1)) >> 1);
    assign left_w    = {1'b0, hole_reg, 1'b1};
    assign right_w   = left_w + (PW+2)'(1);
    assign left_i    = left_w[PW-1:0];
    assign right_i   = right_w[PW-1:0];
    assign best_i    = ((right_w < (PW+2)'(cnt_reg)) &&
                        (heap_key_reg[right_i] > heap_key_reg[left_i])) ? right_i : left_i;

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        hole_next       = hole_reg;
        cur_id_next     = cur_id_reg;
        cur_key_next    = cur_key_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_key_next    = res_key_reg;
        present_next    = present_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        heap_we         = 1'b0;
        heap_wslot      = hole_reg;
        heap_wid        = cur_id_reg;
        heap_wkey       = cur_key_reg;
        pos_we          = 1'b0;
        pos_wid         = cur_id_reg;
        pos_wval        = hole_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_status_next = ST_OK;
                    res_id_next     = cmd.id;
                    res_key_next    = '0;
                    cur_id_next     = cid;
                    cur_key_next    = cmd.key;
                    state_next      = S_FIN;
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            if (!cmd.in_range)
                                res_status_next = ST_RANGE;
                            else if (present_reg[cid])
                                res_status_next = ST_PRESENT;
                            else if (cnt_reg >= CW'(NID))
                                res_status_next = ST_FULL;
                            else
                            begin
                                present_next[cid] = 1'b1;
                                hole_next         = PW'(cnt_reg);
                                cnt_next          = cnt_reg + CW'(1);
                                state_next        = S_UP;
                            end
                        end
                        OP_INC, OP_DEC:
                        begin
                            if (!cmd.in_range)
                                res_status_next = ST_RANGE;
                            else if (!present_reg[cid])
                                res_status_next = ST_ABSENT;
                            else if ((cmd.op == OP_INC) && !(cmd.key > ckey))
                                res_status_next = ST_NOMOVE;
                            else if ((cmd.op == OP_DEC) && !(cmd.key < ckey))
                                res_status_next = ST_NOMOVE;
                            else
                            begin
                                hole_next  = cpos;
                                state_next = (cmd.op == OP_INC) ? S_UP : S_DOWN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cnt_reg == '0)
                                res_status_next = ST_EMPTY;
                            else
                            begin
                                res_id_next                  = 4'(heap_id_reg[0]);
                                res_key_next                 = heap_key_reg[0];
                                present_next[heap_id_reg[0]] = 1'b0;
                                cnt_next                     = cnt_reg - CW'(1);
                                cur_id_next                  = heap_id_reg[last_slot];
                                cur_key_next                 = heap_key_reg[last_slot];
                                hole_next                    = '0;
                                if (cnt_reg > CW'(1))
                                    state_next = S_DOWN;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (!cmd.in_range)
                                res_status_next = ST_RANGE;
                            else if (!present_reg[cid])
                                res_status_next = ST_ABSENT;
                            else
                                res_key_next = ckey;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if ((hole_reg != '0) && (heap_key_reg[parent] < cur_key_reg))
                begin
                    // Pull the parent down into the hole.
                    heap_wid  = heap_id_reg[parent];
                    heap_wkey = heap_key_reg[parent];
                    pos_wid   = heap_id_reg[parent];
                    hole_next = parent;
                end
                else
                    state_next = S_FIN;
            end
            S_DOWN:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if ((left_w < (PW+2)'(cnt_reg)) && (heap_key_reg[best_i] > cur_key_reg))
                begin
                    // Pull the larger child up into the hole.
                    heap_wid  = heap_id_reg[best_i];
                    heap_wkey = heap_key_reg[best_i];
                    pos_wid   = heap_id_reg[best_i];
                    hole_next = best_i;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_next.status = res_status_reg;
                    out_next.out_id = res_id_reg;
                    out_next.out_key = res_key_reg;
                    out_next.count  = 5'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and stores.
    always_ff @(posedge clk)
    begin
        hole_reg       <= hole_next;
        cur_id_reg     <= cur_id_next;
        cur_key_reg    <= cur_key_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_key_reg    <= res_key_next;
        out_reg        <= out_next;
        if (heap_we)
        begin
            heap_id_reg[heap_wslot]  <= heap_wid;
            heap_key_reg[heap_wslot] <= heap_wkey;
        end
        if (pos_we)
        begin
            pos_reg[pos_wid] <= pos_wval;
        end
    end

endmodule

// ===== rtl/ihq_checker.sv =====
// Port checker for the heap queue and its bind to the top level.
module ihq_checker
    import ihq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // A result beat that was not taken holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Errors and empty removes carry a zero key.
    a_err_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> out_data.out_key == 32'sd0)
        else $error("nonzero key on an error result");

    // An empty remove reports a zero count.
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_EMPTY) |-> out_data.count == 5'd0)
        else $error("empty status with nonzero count");

    // Status codes stay within the defined set and counts within the id space.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status != 3'd7) && (out_data.count <= 5'd16))
        else $error("result status or count out of range");

    // No result appears right after reset.
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind indexed_max_heap_queue ihq_checker u_ihq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
